// ----- rtl/bqc_pkg.sv -----
// ----------------------------------------------------------------------------
// bqc_pkg
// Shared types and constants for the billboard quad corner expander.
// ----------------------------------------------------------------------------
package bqc_pkg;

    // Default angle resolution and depth of the queue between the two halves.
    localparam int AngleBitsDefault = 16;
    localparam int QueueDepth       = 4;

    // Coefficients of the quarter-turn sine polynomial.
    localparam logic [16:0] SinA = 17'd102919;
    localparam logic [15:0] SinB = 16'd42111;
    localparam logic [12:0] SinC = 13'd4737;

    // Configuration register indexes.
    typedef enum logic [3:0] {
        CFG_PIVOT_X          = 4'd0,
        CFG_PIVOT_Y          = 4'd1,
        CFG_SPRITE_WIDTH     = 4'd2,
        CFG_SPRITE_HEIGHT    = 4'd3,
        CFG_INHERIT_POSITION = 4'd4,
        CFG_OFFSET_X         = 4'd5,
        CFG_OFFSET_Y         = 4'd6,
        CFG_OFFSET_Z         = 4'd7
    } t_cfg_index;

    typedef struct packed {
        logic signed [15:0] pivot_x;
        logic signed [15:0] pivot_y;
        logic        [15:0] sprite_width;
        logic        [15:0] sprite_height;
        logic               inherit_position;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic        [15:0] angle;
        logic        [15:0] scale_x;
        logic        [15:0] scale_y;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
        logic signed [15:0] left_x;
        logic signed [15:0] left_y;
        logic signed [15:0] left_z;
    } t_in_item;

    typedef struct packed {
        logic        [1:0]  corner;
        logic signed [31:0] vert_x;
        logic signed [31:0] vert_y;
        logic signed [31:0] vert_z;
        logic               last_corner;
    } t_out_item;

    // One prepared quad: rotated basis, position and the four half extents.
    typedef struct packed {
        logic signed [2:0][17:0] ba;
        logic signed [2:0][17:0] bb;
        logic signed [2:0][32:0] p;
        logic signed [33:0]      ha_left;
        logic signed [33:0]      ha_right_neg;
        logic signed [33:0]      hb_down;
        logic signed [33:0]      hb_up_neg;
    } t_quad;

    // Queue status seen by both halves.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ----- rtl/bqc_queue.sv -----
// ----------------------------------------------------------------------------
// bqc_queue
// Small first-in first-out store of prepared quads between front and back.
// ----------------------------------------------------------------------------
module bqc_queue
    import bqc_pkg::*;
#(
    parameter int DEPTH = QueueDepth
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_quad     i_push_data,
    input  logic      i_pop,
    output t_quad     o_pop_data,
    output t_q_status o_status
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_quad            r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr;
    logic [CntW-1:0]  r_count;

    // Pointers wrap at the last entry.
    function automatic logic [PtrW-1:0] f_next(input logic [PtrW-1:0] ptr);
        if (ptr == PtrW'(DEPTH - 1)) begin
            return '0;
        end
        return ptr + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= f_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= f_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage holds payload only.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_pop_data      = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == CntW'(DEPTH));
    assign o_status.empty  = (r_count == '0);

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(DEPTH))
        else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_status.full))
        else $error("transfer into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_status.empty))
        else $error("read from an empty queue");
`endif

endmodule

// ----- rtl/bqc_front.sv -----
// ----------------------------------------------------------------------------
// bqc_front
// Accepts particles and prepares each quad: sine and cosine, rotated basis,
// half extents and position, in an eight-stage pipeline.
// ----------------------------------------------------------------------------
module bqc_front
    import bqc_pkg::*;
#(
    parameter int ANGLE_BITS = AngleBitsDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    input  t_q_status i_q_status,
    output logic      o_push,
    output t_quad     o_quad
);

    localparam logic [15:0] AngMask = 16'(17'h0FFFF << (16 - ANGLE_BITS));

    typedef struct packed {
        logic signed [2:0][15:0] up;
        logic signed [2:0][15:0] lf;
        logic signed [2:0][32:0] p;
        logic signed [33:0]      ha_left;
        logic signed [33:0]      ha_right_neg;
        logic signed [33:0]      hb_down;
        logic signed [33:0]      hb_up_neg;
    } t_geo;

    logic            fe;
    logic [7:0]      r_v;

    t_in_item        r0_item;
    logic [1:0][14:0] r0_x, r1_x, r2_x, r3_x;
    logic [1:0]      r0_neg, r1_neg, r2_neg, r3_neg, r4_neg;
    logic [1:0][14:0] r1_xx, r2_xx;
    logic [1:0][12:0] r2_t1;
    logic [1:0][15:0] r3_t3;
    logic [1:0][16:0] r4_t5;
    logic signed [15:0] r5_s, r5_c;
    logic signed [2:0][31:0] r6_ls, r6_uc, r6_lc, r6_us;
    t_geo            r_geo [6:1];
    t_quad           r7_quad;

    logic [15:0]      ang_s, ang_c;
    logic [1:0][14:0] n0_x;
    t_geo             n1_geo;

    function automatic logic signed [15:0] f_finish(input logic [16:0] t5, input logic neg);
        logic [15:0] m;
        m = 16'((18'(t5) + 18'd2) >> 2);
        if (m > 16'd16384) begin
            m = 16'd16384;
        end
        return neg ? -$signed(m) : $signed(m);
    endfunction

    // The whole pipeline moves together whenever the queue has room.
    assign fe         = !i_q_status.full;
    assign o_in_stall = !fe || !i_rst_n;

    // Phase within the quarter turn for sine and for cosine.
    always_comb begin
        ang_s = i_in_data.angle & AngMask;
        ang_c = ang_s + 16'h4000;
        n0_x[0] = ang_s[14] ? 15'(15'd16384 - {1'b0, ang_s[13:0]}) : {1'b0, ang_s[13:0]};
        n0_x[1] = ang_c[14] ? 15'(15'd16384 - {1'b0, ang_c[13:0]}) : {1'b0, ang_c[13:0]};
    end

    // Half extents and position from the accepted particle.
    always_comb begin
        logic signed [16:0] sx;
        logic signed [16:0] sy;
        logic signed [17:0] wmp;
        logic signed [17:0] hmp;
        sx  = $signed({1'b0, r0_item.scale_x});
        sy  = $signed({1'b0, r0_item.scale_y});
        wmp = $signed({2'b00, i_cfg.sprite_width}) - 18'(i_cfg.pivot_x);
        hmp = $signed({2'b00, i_cfg.sprite_height}) - 18'(i_cfg.pivot_y);
        n1_geo.ha_left      = 34'(i_cfg.pivot_x) * 34'(sx);
        n1_geo.ha_right_neg = -(34'(wmp) * 34'(sx));
        n1_geo.hb_down      = 34'(hmp) * 34'(sy);
        n1_geo.hb_up_neg    = -(34'(i_cfg.pivot_y) * 34'(sy));
        n1_geo.up[0] = r0_item.up_x;
        n1_geo.up[1] = r0_item.up_y;
        n1_geo.up[2] = r0_item.up_z;
        n1_geo.lf[0] = r0_item.left_x;
        n1_geo.lf[1] = r0_item.left_y;
        n1_geo.lf[2] = r0_item.left_z;
        n1_geo.p[0] = 33'(r0_item.pos_x) + (i_cfg.inherit_position ? 33'(i_cfg.offset_x) : '0);
        n1_geo.p[1] = 33'(r0_item.pos_y) + (i_cfg.inherit_position ? 33'(i_cfg.offset_y) : '0);
        n1_geo.p[2] = 33'(r0_item.pos_z) + (i_cfg.inherit_position ? 33'(i_cfg.offset_z) : '0);
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (fe) begin
            r_v <= {r_v[6:0], i_in_valid};
        end
    end

    // Datapath stages.
    always_ff @(posedge i_clk) begin
        if (fe) begin
            // Capture and fold the angle.
            r0_item   <= i_in_data;
            r0_x      <= n0_x;
            r0_neg[0] <= ang_s[15];
            r0_neg[1] <= ang_c[15];

            // Polynomial steps, one multiply each.
            for (int i = 0; i < 2; i++) begin
                r1_xx[i] <= 15'((30'(r0_x[i]) * 30'(r0_x[i])) >> 14);
                r2_t1[i] <= 13'((28'(SinC) * 28'(r1_xx[i])) >> 14);
                r3_t3[i] <= 16'((31'(SinB - 16'(r2_t1[i])) * 31'(r2_xx[i])) >> 14);
                r4_t5[i] <= 17'((32'(SinA - 17'(r3_t3[i])) * 32'(r3_x[i])) >> 14);
            end
            r1_x   <= r0_x;
            r2_x   <= r1_x;
            r3_x   <= r2_x;
            r2_xx  <= r1_xx;
            r1_neg <= r0_neg;
            r2_neg <= r1_neg;
            r3_neg <= r2_neg;
            r4_neg <= r3_neg;

            // Round to Q14, clamp, and apply the sign of the half turn.
            r5_s <= f_finish(r4_t5[0], r4_neg[0]);
            r5_c <= f_finish(r4_t5[1], r4_neg[1]);

            // Geometry travels alongside the sine pipeline.
            r_geo[1] <= n1_geo;
            for (int j = 2; j <= 6; j++) begin
                r_geo[j] <= r_geo[j-1];
            end

            // Basis products; the vector components are signed.
            for (int k = 0; k < 3; k++) begin
                r6_ls[k] <= 32'($signed(r_geo[5].lf[k])) * 32'(r5_s);
                r6_uc[k] <= 32'($signed(r_geo[5].up[k])) * 32'(r5_c);
                r6_lc[k] <= 32'($signed(r_geo[5].lf[k])) * 32'(r5_c);
                r6_us[k] <= 32'($signed(r_geo[5].up[k])) * 32'(r5_s);
            end

            // Rotated basis rounded to Q14.
            for (int k = 0; k < 3; k++) begin
                r7_quad.ba[k] <= 18'((33'($signed(r6_ls[k])) + 33'($signed(r6_uc[k]))
                                      + 33'sd8192) >>> 14);
                r7_quad.bb[k] <= 18'((33'($signed(r6_lc[k])) - 33'($signed(r6_us[k]))
                                      + 33'sd8192) >>> 14);
            end
            r7_quad.p            <= r_geo[6].p;
            r7_quad.ha_left      <= r_geo[6].ha_left;
            r7_quad.ha_right_neg <= r_geo[6].ha_right_neg;
            r7_quad.hb_down      <= r_geo[6].hb_down;
            r7_quad.hb_up_neg    <= r_geo[6].hb_up_neg;
        end
    end

    assign o_push = fe && r_v[7];
    assign o_quad = r7_quad;

endmodule

// ----- rtl/bqc_back.sv -----
// ----------------------------------------------------------------------------
// bqc_back
// Expands each prepared quad into its four corners with rounding, saturation
// and a registered output, one corner per cycle unless stalled or queue empty.
// ----------------------------------------------------------------------------
module bqc_back
    import bqc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_quad     i_quad,
    input  t_q_status i_q_status,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic                    be;
    logic                    issue;
    logic [1:0]              r_corner;
    logic                    r_b1_v, r_b2_v, r_out_v;
    logic signed [2:0][51:0] r_b1_pa, r_b1_pb;
    logic signed [2:0][32:0] r_b1_p, r_b2_p;
    logic [1:0]              r_b1_corner, r_b2_corner;
    logic signed [2:0][40:0] r_b2_term;
    t_out_item               r_out;
    logic signed [33:0]      ha, hb;
    logic signed [2:0][31:0] n_vert;

    // The back pipeline advances unless a finished corner is held.
    assign be    = !(r_out_v && i_out_stall);
    assign issue = be && !i_q_status.empty;
    assign o_pop = issue && (r_corner == 2'd3);

    assign ha = r_corner[1] ? i_quad.ha_right_neg : i_quad.ha_left;
    assign hb = r_corner[0] ? i_quad.hb_up_neg : i_quad.hb_down;

    // Add the position and saturate to signed 32 bits.
    always_comb begin
        logic signed [41:0] v;
        for (int k = 0; k < 3; k++) begin
            v = 42'($signed(r_b2_term[k])) + 42'($signed(r_b2_p[k]));
            if (v[41:31] == '0 || v[41:31] == '1) begin
                n_vert[k] = v[31:0];
            end else if (v[41]) begin
                n_vert[k] = 32'h8000_0000;
            end else begin
                n_vert[k] = 32'h7FFF_FFFF;
            end
        end
    end

    // Control: corner counter and stage valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner <= '0;
            r_b1_v   <= 1'b0;
            r_b2_v   <= 1'b0;
            r_out_v  <= 1'b0;
        end else if (be) begin
            if (issue) begin
                r_corner <= r_corner + 1'b1;
            end
            r_b1_v  <= issue;
            r_b2_v  <= r_b1_v;
            r_out_v <= r_b2_v;
        end
    end

    // Datapath: products, rounded term, saturated sum.
    always_ff @(posedge i_clk) begin
        if (be) begin
            for (int k = 0; k < 3; k++) begin
                r_b1_pa[k]   <= 52'($signed(i_quad.ba[k])) * 52'(ha);
                r_b1_pb[k]   <= 52'($signed(i_quad.bb[k])) * 52'(hb);
                r_b2_term[k] <= 41'((r_b1_pa[k] + r_b1_pb[k] + 52'sd1024) >>> 11);
            end
            r_b1_p      <= i_quad.p;
            r_b1_corner <= r_corner;
            r_b2_p      <= r_b1_p;
            r_b2_corner <= r_b1_corner;

            r_out.corner      <= r_b2_corner;
            r_out.vert_x      <= n_vert[0];
            r_out.vert_y      <= n_vert[1];
            r_out.vert_z      <= n_vert[2];
            r_out.last_corner <= (r_b2_corner == 2'd3);
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/billboard_quad_corners_core.sv -----
// ----------------------------------------------------------------------------
// billboard_quad_corners_core
// Each particle passes the eight-stage front, the queue and the three-stage
// back; its corners follow one per cycle while the output is not stalled.
// The back emits the four corners of a particle in turn and so sets throughput.
// The front takes a particle each cycle until the four-entry queue is full.
// Synchronous active-low reset clears control state and the configuration
// registers to 0; datapath registers are not reset.
// ----------------------------------------------------------------------------
module billboard_quad_corners_core
    import bqc_pkg::*;
#(
    parameter int ANGLE_BITS = AngleBitsDefault,
    parameter int Q_DEPTH    = QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data
);

    t_cfg      r_cfg;
    t_q_status q_status;
    logic      push, pop;
    t_quad     push_quad, pop_quad;

    // Configuration register file; unknown indexes are ignored and no write
    // is taken while reset is held.
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PIVOT_X:          r_cfg.pivot_x          <= i_cfg_data[15:0];
                CFG_PIVOT_Y:          r_cfg.pivot_y          <= i_cfg_data[15:0];
                CFG_SPRITE_WIDTH:     r_cfg.sprite_width     <= i_cfg_data[15:0];
                CFG_SPRITE_HEIGHT:    r_cfg.sprite_height    <= i_cfg_data[15:0];
                CFG_INHERIT_POSITION: r_cfg.inherit_position <= i_cfg_data[0];
                CFG_OFFSET_X:         r_cfg.offset_x         <= i_cfg_data;
                CFG_OFFSET_Y:         r_cfg.offset_y         <= i_cfg_data;
                CFG_OFFSET_Z:         r_cfg.offset_z         <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Front: particle intake and quad preparation.
    bqc_front #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_status (q_status),
        .o_push     (push),
        .o_quad     (push_quad)
    );

    // Queue between the halves.
    bqc_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_quad),
        .i_pop       (pop),
        .o_pop_data  (pop_quad),
        .o_status    (q_status)
    );

    // Back: corner expansion.
    bqc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_quad      (pop_quad),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
